/* hdl/rmwf_pkg.sv */
// ----------------------------------------------------------------------------
// rmwf_pkg: shared types and constants of the RGB median window filter
// Pixel payload widths, line length and config register indexes.
// ----------------------------------------------------------------------------
package rmwf_pkg;

	localparam int CH_W      = 8;
	localparam int ROW_W     = 12;
	localparam int COL_W     = 11;
	localparam int FW_W      = 12;
	localparam int FH_W      = 13;
	localparam int CFG_W     = 13;
	localparam int CFGI_W    = 1;
	localparam int MAX_WIDTH = 2048;

	typedef enum logic [CFGI_W-1:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [CH_W-1:0] ch2;
		logic [CH_W-1:0] ch1;
		logic [CH_W-1:0] ch0;
	} pix_t;

	function automatic logic [CH_W-1:0] med3(input logic [CH_W-1:0] a,
		input logic [CH_W-1:0] b, input logic [CH_W-1:0] c);
		logic [CH_W-1:0] lo;
		logic [CH_W-1:0] hi;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		return (c < lo) ? lo : ((c > hi) ? hi : c);
	endfunction

endpackage

/* hdl/rmwf_if.sv */
// ----------------------------------------------------------------------------
// rmwf_in_if / rmwf_out_if: valid/ready channels of the median filter
// A transfer happens when valid and ready are both high at a clock edge.
// ----------------------------------------------------------------------------
interface rmwf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel_ch0;
	logic [7:0] pixel_ch1;
	logic [7:0] pixel_ch2;
	modport source (output valid, pixel_ch0, pixel_ch1, pixel_ch2, input ready);
	modport sink   (input valid, pixel_ch0, pixel_ch1, pixel_ch2, output ready);
endinterface

interface rmwf_out_if;
	logic        valid;
	logic        ready;
	logic [11:0] out_row;
	logic [10:0] out_col;
	logic [7:0]  out_ch0;
	logic [7:0]  out_ch1;
	logic [7:0]  out_ch2;
	logic        run_last;
	modport source (output valid, out_row, out_col, out_ch0, out_ch1, out_ch2, run_last,
		input ready);
	modport sink   (input valid, out_row, out_col, out_ch0, out_ch1, out_ch2, run_last,
		output ready);
endinterface

/* hdl/rgb_median_window_filter.sv */
// ----------------------------------------------------------------------------
// rgb_median_window_filter: 3x3 per-channel median filter on an RGB stream
// Line store in one RAM, three-column window, border pass-through.
// ----------------------------------------------------------------------------
// channel  dir  contents
// pix_in   in   pixel_ch0..2
// res_out  out  out_row, out_col, out_ch0..2, run_last
// cfg      in   cfg_we, cfg_idx, cfg_data
//
// One pixel per clock while the result queue has room. The line store is one
// RAM (one write port, one registered read port); each word holds the two
// earlier rows at its column, forwarded when the same column is read back.
// Results are formed in the cycle after the pixel transfer and go through an
// 8-entry queue; input stalls while queue count plus results being pushed > 5.
// Reset clears control and configuration only, not the RAM.
// ----------------------------------------------------------------------------
module rgb_median_window_filter (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [rmwf_pkg::CFGI_W-1:0] cfg_idx,
	input  logic [rmwf_pkg::CFG_W-1:0]  cfg_data,
	rmwf_in_if.sink                     pix_in,
	rmwf_out_if.source                  res_out
);
	import rmwf_pkg::*;

	localparam int PW    = $bits(pix_t);
	localparam int QD    = 8;
	localparam int QA    = 3;
	localparam int CW    = QA + 1;
	localparam int QFREE = QD - 3;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		pix_t             px;
		logic             last;
	} res_t;

	// config
	logic [FW_W-1:0] fw_q;
	logic [FH_W-1:0] fh_q;
	logic [12:0]     w_eff;
	logic [12:0]     h_eff;
	logic [COL_W-1:0] wm1;
	always_comb begin
		w_eff = {1'b0, fw_q};
		if (fw_q == '0) w_eff = 13'd1;
		if (w_eff > 13'(MAX_WIDTH)) w_eff = 13'(MAX_WIDTH);
		h_eff = fh_q;
		if (fh_q == '0) h_eff = 13'd1;
		if (h_eff > 13'd4096) h_eff = 13'd4096;
		wm1 = COL_W'(w_eff - 13'd1);
	end

	// line store: word holds rows r-1 (hi) and r-2 (lo) at each column
	logic [2*PW-1:0] mem [MAX_WIDTH];
	logic [2*PW-1:0] ram_s1;
	logic [2*PW-1:0] fwd_s1;
	logic            byp_s1;
	logic [2*PW-1:0] rd_word;
	logic [2*PW-1:0] wr_word;

	// counters
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;

	// queue
	res_t            q_mem [QD];
	logic [QA-1:0]   wp_q, rp_q;
	logic [QA:0]     cnt_q;

	logic acc;
	logic [QA:0] nres;
	res_t r0, r1, r2;
	logic [1:0] npush;

	// stage 1 regs (pixel accepted, RAM read in flight)
	logic             v_s1;
	pix_t             px_s1;
	logic [ROW_W-1:0] row_s1;
	logic [COL_W-1:0] col_s1;

	// window columns: each holds rows r-2, r-1, r
	pix_t wa_q [3];
	pix_t wb_q [3];
	pix_t wc [3];

	assign pix_in.ready = (cnt_q + CW'(npush)) <= CW'(QFREE);

	assign acc = pix_in.valid && pix_in.ready;

	assign rd_word = byp_s1 ? fwd_s1 : ram_s1;
	assign wr_word = {px_s1, rd_word[2*PW-1 -: PW]};

	always_ff @(posedge clk) begin
		ram_s1 <= mem[col_q];
		if (v_s1)
			mem[col_s1] <= wr_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= 12'd640;
			fh_q <= 13'd480;
			row_q <= '0;
			col_q <= '0;
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= acc;
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_idx))
					REG_FRAME_WIDTH:  fw_q <= cfg_data[FW_W-1:0];
					REG_FRAME_HEIGHT: fh_q <= cfg_data;
					default: ;
				endcase
				row_q <= '0;
				col_q <= '0;
			end else if (acc) begin
				if (col_q == wm1) begin
					col_q <= '0;
					row_q <= ({1'b0, row_q} + 13'd1 >= h_eff) ? '0 : row_q + 12'd1;
				end else
					col_q <= col_q + 11'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		px_s1 <= '{ch2: pix_in.pixel_ch2, ch1: pix_in.pixel_ch1, ch0: pix_in.pixel_ch0};
		row_s1 <= row_q;
		col_s1 <= col_q;
		byp_s1 <= v_s1 && (col_s1 == col_q);
		fwd_s1 <= wr_word;
	end

	// window shift
	always_comb begin
		wc[0] = rd_word[PW-1:0];
		wc[1] = rd_word[2*PW-1 -: PW];
		wc[2] = px_s1;
	end
	always_ff @(posedge clk) begin
		if (v_s1) begin
			wa_q <= wb_q;
			wb_q <= wc;
		end
	end

	function automatic logic [CH_W-1:0] med9(input pix_t a [3], input pix_t b [3],
		input pix_t c [3], input int ch);
		logic [CH_W-1:0] x [9];
		logic [CH_W-1:0] mx [3], md [3], mn [3];
		for (int i = 0; i < 3; i++) begin
			x[i]   = a[i][ch*CH_W +: CH_W];
			x[3+i] = b[i][ch*CH_W +: CH_W];
			x[6+i] = c[i][ch*CH_W +: CH_W];
		end
		for (int i = 0; i < 3; i++) begin
			mn[i] = (x[3*i] < x[3*i+1]) ? ((x[3*i] < x[3*i+2]) ? x[3*i] : x[3*i+2])
				: ((x[3*i+1] < x[3*i+2]) ? x[3*i+1] : x[3*i+2]);
			mx[i] = (x[3*i] > x[3*i+1]) ? ((x[3*i] > x[3*i+2]) ? x[3*i] : x[3*i+2])
				: ((x[3*i+1] > x[3*i+2]) ? x[3*i+1] : x[3*i+2]);
			md[i] = med3(x[3*i], x[3*i+1], x[3*i+2]);
		end
		return med3(((mx[0] < mx[1]) ? ((mx[0] < mx[2]) ? mx[0] : mx[2])
				: ((mx[1] < mx[2]) ? mx[1] : mx[2])),
			med3(md[0], md[1], md[2]),
			((mn[0] > mn[1]) ? ((mn[0] > mn[2]) ? mn[0] : mn[2])
				: ((mn[1] > mn[2]) ? mn[1] : mn[2])));
	endfunction

	// result generation in stage 1
	logic e0, e1, e2;
	pix_t ctr, medv;
	always_comb begin
		ctr = wb_q[1];
		medv.ch0 = med9(wa_q, wb_q, wc, 0);
		medv.ch1 = med9(wa_q, wb_q, wc, 1);
		medv.ch2 = med9(wa_q, wb_q, wc, 2);
		e0 = 1'b0; e1 = 1'b0; e2 = 1'b0;
		r0 = '0; r1 = '0; r2 = '0;
		if (v_s1) begin
			e0 = (row_s1 >= 12'd1) && (col_s1 >= 11'd1);
			r0.row = row_s1 - 12'd1; r0.col = col_s1 - 11'd1;
			r0.px = (row_s1 >= 12'd2 && col_s1 >= 11'd2) ? medv : ctr;
			e1 = (col_s1 == wm1) && (row_s1 >= 12'd1);
			r1.row = row_s1 - 12'd1; r1.col = col_s1;
			r1.px = wc[1];
			e2 = ({1'b0, row_s1} + 13'd1 >= h_eff);
			r2.row = row_s1; r2.col = col_s1; r2.px = px_s1;
			r2.last = 1'b1;
			r1.last = !e2;
			r0.last = !e1 && !e2;
		end
	end

	// pack pushes in order
	res_t p [3];
	always_comb begin
		p[0] = r0; p[1] = r1; p[2] = r2;
		npush = 2'd0;
		if (e0) begin p[npush] = r0; npush = npush + 2'd1; end
		if (e1) begin p[npush] = r1; npush = npush + 2'd1; end
		if (e2) begin p[npush] = r2; npush = npush + 2'd1; end
	end

	logic pop;
	assign pop = res_out.valid && res_out.ready;
	assign nres = cnt_q + CW'(npush) - CW'(pop);

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++)
			if (2'(i) < npush) q_mem[wp_q + QA'(i)] <= p[i];
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			wp_q <= wp_q + QA'(npush);
			if (pop) rp_q <= rp_q + QA'(1);
			cnt_q <= nres;
		end
	end

	res_t hd;
	assign hd = q_mem[rp_q];
	assign res_out.valid    = (cnt_q != '0);
	assign res_out.out_row  = hd.row;
	assign res_out.out_col  = hd.col;
	assign res_out.out_ch0  = hd.px.ch0;
	assign res_out.out_ch1  = hd.px.ch1;
	assign res_out.out_ch2  = hd.px.ch2;
	assign res_out.run_last = hd.last;

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CW'(QD))
		else $error("queue overflow");
	a_nopush_full: assert property (@(posedge clk) disable iff (!arst_n)
		pix_in.ready |-> cnt_q <= CW'(QFREE)) else $error("ready with full queue");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_out.valid && !res_out.ready |=> res_out.valid && $stable(hd))
		else $error("result changed while waiting");
endmodule

/* tb/rmwf_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rmwf_checker: scoreboard for the RGB median window filter
// Watches config writes and pixel transfers, predicts the emitted results
// (3x3 per-channel medians, border pass-through, row-end and bottom-row
// flushes) and compares every result transfer field by field in order.
// ----------------------------------------------------------------------------
module rmwf_checker
	import rmwf_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CFGI_W-1:0]   cfg_idx,
	input  logic [CFG_W-1:0]    cfg_data,
	rmwf_in_if                  pin,
	rmwf_out_if                 pout,
	output int                  pending,
	output int                  errors
);

	typedef struct {
		int   row;
		int   col;
		pix_t px;
		bit   last;
	} result_t;

	result_t    result_q[$];
	pix_t       row_mem [3][MAX_WIDTH];
	int         frame_w;
	int         frame_h;
	int         cur_row;
	int         cur_col;

	function automatic logic [7:0] chan(pix_t p, int ch);
		return (ch == 0) ? p.ch0 : ((ch == 1) ? p.ch1 : p.ch2);
	endfunction

	function automatic pix_t median_at(int yc, int xc);
		pix_t       res;
		logic [7:0] v [9];
		logic [7:0] t;
		int         j;
		for (int ch = 0; ch < 3; ch++) begin
			for (int i = 0; i < 9; i++) begin
				t = chan(row_mem[(yc - 1 + i / 3) % 3][xc - 1 + i % 3], ch);
				j = i;
				while (j > 0 && v[j-1] > t) begin
					v[j] = v[j-1];
					j--;
				end
				v[j] = t;
			end
			case (ch)
				0: res.ch0 = v[4];
				1: res.ch1 = v[4];
				default: res.ch2 = v[4];
			endcase
		end
		return res;
	endfunction

	task automatic push_result(int row, int col, pix_t px);
		result_t e;
		e.row  = row;
		e.col  = col;
		e.px   = px;
		e.last = 0;
		result_q.insert(result_q.size(), e);
	endtask

	task automatic predict_pixel(pix_t px);
		int w;
		int h;
		int r;
		int c;
		int n0;
		pix_t v;
		w  = (frame_w < 1) ? 1 : ((frame_w > MAX_WIDTH) ? MAX_WIDTH : frame_w);
		h  = (frame_h < 1) ? 1 : ((frame_h > 4096) ? 4096 : frame_h);
		r  = (cur_row >= h) ? 0 : cur_row;
		c  = (cur_col >= w) ? 0 : cur_col;
		n0 = result_q.size();
		row_mem[r % 3][c] = px;
		if (r >= 1 && c >= 1) begin
			if (r >= 2 && c >= 2)
				v = median_at(r - 1, c - 1);
			else
				v = row_mem[(r - 1) % 3][c - 1];
			push_result(r - 1, c - 1, v);
		end
		if (c == w - 1 && r >= 1)
			for (int x = (w > 1) ? w - 1 : 0; x < w; x++)
				push_result(r - 1, x, row_mem[(r - 1) % 3][x]);
		if (r + 1 >= h)
			push_result(r, c, px);
		if (result_q.size() > n0)
			result_q[result_q.size() - 1].last = 1;
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h)
				r = 0;
		end
		cur_row = r;
		cur_col = c;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t e;
		pix_t    got;
		if (!arst_n) begin
			result_q.delete();
			frame_w = 640;
			frame_h = 480;
			cur_row = 0;
			cur_col = 0;
			errors  = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == REG_FRAME_WIDTH)
					frame_w = cfg_data[FW_W-1:0];
				else
					frame_h = cfg_data[FH_W-1:0];
				cur_row = 0;
				cur_col = 0;
			end
			if (pin.valid && pin.ready)
				predict_pixel('{ch2: pin.pixel_ch2, ch1: pin.pixel_ch1, ch0: pin.pixel_ch0});
			if (pout.valid && pout.ready) begin
				got = '{ch2: pout.out_ch2, ch1: pout.out_ch1, ch0: pout.out_ch0};
				if (result_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result row %0d col %0d px %h",
							pout.out_row, pout.out_col, got);
				end else begin
					e = result_q.pop_front();
					if (pout.out_row !== e.row[ROW_W-1:0] || pout.out_col !== e.col[COL_W-1:0]
							|| got !== e.px || pout.run_last !== e.last) begin
						errors++;
						if (errors <= 10)
							$display("exp r%0d c%0d px %h l%0d got r%0d c%0d px %h l%0d",
								e.row, e.col, e.px, e.last,
								pout.out_row, pout.out_col, got, pout.run_last);
					end
				end
			end
			pending = result_q.size();
		end
	end

endmodule

/* tb/tb_rgb_median_window_filter.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rgb_median_window_filter: stimulus and verdict for the median filter
// Directed frames at the size extremes, then random frame sizes with random
// pixels, random idling on both channels and a scoreboard beside the block.
// ----------------------------------------------------------------------------
module tb_rgb_median_window_filter;
	import rmwf_pkg::*;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [CFGI_W-1:0] cfg_idx;
	logic [CFG_W-1:0]  cfg_data;
	int                pending;
	int                errors;
	int                sent;
	int                cycles;
	bit                quiet;

	rmwf_in_if  pix_in ();
	rmwf_out_if res_out ();

	rgb_median_window_filter u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_idx (cfg_idx),
		.cfg_data(cfg_data),
		.pix_in  (pix_in),
		.res_out (res_out)
	);

	rmwf_checker u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_idx (cfg_idx),
		.cfg_data(cfg_data),
		.pin     (pix_in),
		.pout    (res_out),
		.pending (pending),
		.errors  (errors)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_out.ready <= 1'b0;
		else
			res_out.ready <= quiet || ($urandom_range(99) >= 9);
	end

	task automatic send_pixel(pix_t p);
		while (!quiet && $urandom_range(99) < 9) begin
			pix_in.valid <= 1'b0;
			@(posedge clk);
		end
		pix_in.valid     <= 1'b1;
		pix_in.pixel_ch0 <= p.ch0;
		pix_in.pixel_ch1 <= p.ch1;
		pix_in.pixel_ch2 <= p.ch2;
		do @(posedge clk); while (!pix_in.ready);
		sent++;
		quiet = (sent >= 150 && sent < 230);
	endtask

	task automatic drain;
		pix_in.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, int val);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val[CFG_W-1:0];
		@(posedge clk);
		cfg_we   <= 1'b0;
		@(posedge clk);
	endtask

	function automatic pix_t rand_pixel();
		pix_t p;
		p = pix_t'($urandom);
		if ($urandom_range(7) == 0)
			p = $urandom_range(1) ? '1 : '0;
		return p;
	endfunction

	task automatic run_frame(int w, int h, int n, bit hold_mid);
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
		for (int i = 0; i < n; i++) begin
			if (hold_mid && i == n / 2) begin
				pix_in.valid <= 1'b0;
				@(posedge clk);
				while (pending != 0)
					@(posedge clk);
			end
			send_pixel(rand_pixel());
		end
		drain();
	endtask

	initial begin
		int w;
		int h;
		int n;
		int ph;
		cycles           = 0;
		sent             = 0;
		quiet            = 0;
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_idx          = REG_FRAME_WIDTH;
		cfg_data         = '0;
		pix_in.valid     = 1'b0;
		pix_in.pixel_ch0 = '0;
		pix_in.pixel_ch1 = '0;
		pix_in.pixel_ch2 = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// smallest full frame with extreme values, then a second frame
		write_reg(REG_FRAME_WIDTH, 3);
		write_reg(REG_FRAME_HEIGHT, 3);
		for (int i = 0; i < 9; i++)
			send_pixel((i % 2) ? pix_t'('1) : pix_t'('0));
		for (int i = 0; i < 9; i++)
			send_pixel(pix_t'({8'(i * 31), 8'(255 - i * 17), 8'(i * 7 + 100)}));
		drain();
		// zero width and height act as one
		run_frame(0, 0, 3, 0);
		// oversized width and height clamp
		run_frame(4095, 8191, 4, 0);

		ph = 0;
		while (sent < 370) begin
			case ($urandom_range(9))
				0: begin w = $urandom_range(1, 2); h = $urandom_range(1, 5); end
				1: begin w = $urandom_range(3, 6); h = $urandom_range(1, 2); end
				default: begin w = $urandom_range(3, 10); h = $urandom_range(3, 6); end
			endcase
			n = w * h * $urandom_range(1, 2) + $urandom_range(0, 3);
			if (n > 60)
				n = 60;
			run_frame(w, h, n, ph == 2);
			ph++;
		end

		drain();
		repeat (30) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* files.f */
hdl/rmwf_pkg.sv
hdl/rmwf_if.sv
hdl/rgb_median_window_filter.sv
tb/rmwf_checker.sv
tb/tb_rgb_median_window_filter.sv
